// ----- src/marching_squares_cell_unit_defines.svh -----
// ---------------------------------------------------------------------------
// marching_squares_cell_unit_defines.svh
// Assertion macros shared by the contour cell unit.
// ---------------------------------------------------------------------------
`ifndef MARCHING_SQUARES_CELL_UNIT_DEFINES_SVH
`define MARCHING_SQUARES_CELL_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/msc_pkg.sv -----
// ---------------------------------------------------------------------------
// msc_pkg
// Types, constants and helpers of the marching squares cell unit.
// ---------------------------------------------------------------------------
`default_nettype none
package msc_pkg;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  // quotient bits of the edge interpolation (distance below one step)
  localparam int QW    = 31;
  localparam int NUM_W = 64;
  localparam int DEN_W = 34;

  localparam logic [2:0] REG_ISO_LEVEL = 3'd0;
  localparam logic [2:0] REG_X_ORIGIN  = 3'd1;
  localparam logic [2:0] REG_Y_ORIGIN  = 3'd2;
  localparam logic [2:0] REG_STEP_X    = 3'd3;
  localparam logic [2:0] REG_STEP_Y    = 3'd4;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_START  = 2'd1,
    MODE_END    = 2'd2,
    MODE_INTERP = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pt_t;

  typedef struct packed {
    pt_t a;
    pt_t b;
  } seg_t;

  typedef struct packed {
    logic [9:0]         col;
    logic [9:0]         row;
    mode_t [3:0]        mode;
    logic               around;
    logic signed [44:0] cx0;
    logic signed [44:0] cx1;
    logic signed [44:0] cy0;
    logic signed [44:0] cy1;
  } ctx_t;

  function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
    if (v > 46'sh0_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -46'sh0_0000_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- src/msc_div.sv -----
// ---------------------------------------------------------------------------
// msc_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none
module msc_div #(
  parameter int NW = msc_pkg::NUM_W,
  parameter int DW = msc_pkg::DEN_W,
  parameter int QB = msc_pkg::QW
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [QB-1:0] quo
);

  logic [NW-1:0] rem_q [QB];
  logic [DW-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [NW-1:0] rin;
    logic [DW-1:0] din;
    logic [QB-1:0] qin;
    logic [NW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rin = num;
      assign din = den;
      assign qin = '0;
    end else begin : g_rest
      assign rin = rem_q[k-1];
      assign din = den_q[k-1];
      assign qin = quo_q[k-1];
    end

    assign trial = NW'(din) << (QB - 1 - k);
    assign ge    = rin >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? rin - trial : rin;
        den_q[k] <= din;
        quo_q[k] <= qin | (QB'(ge) << (QB - 1 - k));
      end
    end
  end

  assign quo = quo_q[QB-1];

endmodule
`default_nettype wire

// ----- src/marching_squares_cell_unit.sv -----
// A cell passes stages 1 to 5, the edge divider, stages 6 and 7, the held stage 8 and
// the output register before out_valid rises with its first segment.
// Throughput: one cell per cycle unless out_ready stalls or a cell has a second segment.
// Depth is set by the 31-stage edge divider (one quotient bit per stage).
// Reset (synchronous, active high) clears all valid bits and loads register defaults.
// ---------------------------------------------------------------------------
// marching_squares_cell_unit
// Contour segment generator for one lattice cell per transaction.
// ---------------------------------------------------------------------------
`default_nettype none
`include "marching_squares_cell_unit_defines.svh"
module marching_squares_cell_unit #(
  parameter int MAX_COLS = msc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = msc_pkg::DEF_MAX_ROWS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  // cell input
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [9:0]         cell_col,
  input  wire logic [9:0]         cell_row,
  input  wire logic signed [31:0] corner_ll,
  input  wire logic signed [31:0] corner_lr,
  input  wire logic signed [31:0] corner_ur,
  input  wire logic signed [31:0] corner_ul,
  input  wire logic [3:0]         corner_invalid,
  // segment output
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      seg_ax,
  output logic signed [31:0]      seg_ay,
  output logic signed [31:0]      seg_bx,
  output logic signed [31:0]      seg_by,
  output logic [9:0]              out_col,
  output logic [9:0]              out_row,
  output logic                    last_seg
);

  localparam int L = msc_pkg::QW;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic signed [31:0] iso_level, x_origin, y_origin;
  logic [30:0]        step_x, step_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      iso_level <= '0;
      x_origin  <= '0;
      y_origin  <= '0;
      step_x    <= 31'd65536;
      step_y    <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msc_pkg::REG_ISO_LEVEL: iso_level <= cfg_data;
        msc_pkg::REG_X_ORIGIN:  x_origin  <= cfg_data;
        msc_pkg::REG_Y_ORIGIN:  y_origin  <= cfg_data;
        msc_pkg::REG_STEP_X:    step_x    <= cfg_data[30:0];
        msc_pkg::REG_STEP_Y:    step_y    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves together when the final stage frees up.
  logic adv;
  assign in_ready = adv;

  // -------------------------------------------------------------------------
  // Stage 1: capture the cell
  // -------------------------------------------------------------------------
  logic               s1_valid;
  logic [9:0]         s1_col, s1_row;
  logic signed [31:0] s1_v [4];
  logic [3:0]         s1_inv;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col  <= cell_col;
      s1_row  <= cell_row;
      s1_v[0] <= corner_ll;
      s1_v[1] <= corner_lr;
      s1_v[2] <= corner_ur;
      s1_v[3] <= corner_ul;
      s1_inv  <= corner_invalid;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: level offsets, corner sum, index products
  // -------------------------------------------------------------------------
  logic               s2_valid, s2_ok;
  logic [9:0]         s2_col, s2_row;
  logic [3:0]         s2_inv;
  logic signed [32:0] s2_s [4];
  logic signed [33:0] s2_sum;
  logic [40:0]        s2_px, s2_py;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_col <= s1_col;
      s2_row <= s1_row;
      s2_inv <= s1_inv;
      s2_ok  <= (17'(s1_col) < 17'(MAX_COLS)) && (17'(s1_row) < 17'(MAX_ROWS));
      for (int i = 0; i < 4; i++) begin
        s2_s[i] <= 33'(s1_v[i]) - 33'(iso_level);
      end
      s2_sum <= 34'(s1_v[0]) + 34'(s1_v[1]) + 34'(s1_v[2]) + 34'(s1_v[3]);
      s2_px  <= 41'(s1_col) * 41'(step_x);
      s2_py  <= 41'(s1_row) * 41'(step_y);
    end
  end

  // -------------------------------------------------------------------------
  // Stage 3: edge classification, magnitudes, saddle test, low corners
  // -------------------------------------------------------------------------
  logic               s3_valid, s3_around;
  logic [9:0]         s3_col, s3_row;
  msc_pkg::mode_t     s3_mode [4];
  logic [32:0]        s3_mag [4];
  logic [33:0]        s3_den [4];
  logic signed [44:0] s3_cx0, s3_cy0;

  msc_pkg::mode_t     mode_c [4];
  logic [32:0]        mag_c [4];
  logic signed [32:0] center_c;
  logic               around_c;

  always_comb begin
    logic signed [32:0] a, b;
    for (int e = 0; e < 4; e++) begin
      a = s2_s[e];
      b = s2_s[(e + 1) % 4];
      mag_c[e] = a[32] ? 33'(-a) : 33'(a);
      if (!s2_ok || s2_inv[e] || s2_inv[(e + 1) % 4]) begin
        mode_c[e] = msc_pkg::MODE_NONE;
      end else if (a == 0 && b == 0) begin
        mode_c[e] = msc_pkg::MODE_NONE;
      end else if (a == 0) begin
        mode_c[e] = msc_pkg::MODE_START;
      end else if (b == 0) begin
        mode_c[e] = msc_pkg::MODE_END;
      end else if (a[32] == b[32]) begin
        mode_c[e] = msc_pkg::MODE_NONE;
      end else begin
        mode_c[e] = msc_pkg::MODE_INTERP;
      end
    end
    // floored mean of the corners against the level decides the saddle
    center_c = 33'(s2_sum >>> 2) - 33'(iso_level);
    around_c = (s2_s[0][32] && s2_s[2][32] && center_c[32]) ||
               (!s2_s[0][32] && s2_s[0] != 0 && !s2_s[2][32] && s2_s[2] != 0 &&
                !center_c[32] && center_c != 0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_col    <= s2_col;
      s3_row    <= s2_row;
      s3_around <= around_c;
      for (int e = 0; e < 4; e++) begin
        s3_mode[e] <= mode_c[e];
        s3_mag[e]  <= mag_c[e];
        s3_den[e]  <= 34'(mag_c[e]) + 34'(mag_c[(e + 1) % 4]);
      end
      s3_cx0 <= 45'(x_origin) + $signed({4'b0, s2_px});
      s3_cy0 <= 45'(y_origin) + $signed({4'b0, s2_py});
    end
  end

  // -------------------------------------------------------------------------
  // Stage 4: partial products of step * |a|, high corners
  // -------------------------------------------------------------------------
  logic               s4_valid, s4_around;
  logic [9:0]         s4_col, s4_row;
  msc_pkg::mode_t     s4_mode [4];
  logic [33:0]        s4_den [4];
  logic [46:0]        s4_pplo [4];
  logic [47:0]        s4_pphi [4];
  logic signed [44:0] s4_cx0, s4_cx1, s4_cy0, s4_cy1;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_col    <= s3_col;
      s4_row    <= s3_row;
      s4_around <= s3_around;
      for (int e = 0; e < 4; e++) begin
        s4_mode[e] <= s3_mode[e];
        s4_den[e]  <= s3_den[e];
        s4_pplo[e] <= 47'(e[0] ? step_y : step_x) * 47'(s3_mag[e][15:0]);
        s4_pphi[e] <= 48'(e[0] ? step_y : step_x) * 48'(s3_mag[e][32:16]);
      end
      s4_cx0 <= s3_cx0;
      s4_cy0 <= s3_cy0;
      s4_cx1 <= s3_cx0 + 45'(step_x);
      s4_cy1 <= s3_cy0 + 45'(step_y);
    end
  end

  // -------------------------------------------------------------------------
  // Stage 5: assemble numerators and the context that rides beside the divider
  // -------------------------------------------------------------------------
  logic          s5_valid;
  logic [63:0]   s5_num [4];
  logic [33:0]   s5_den [4];
  msc_pkg::ctx_t s5_ctx;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < 4; e++) begin
        s5_num[e]      <= 64'(s4_pplo[e]) + {s4_pphi[e], 16'b0};
        s5_den[e]      <= s4_den[e];
        s5_ctx.mode[e] <= s4_mode[e];
      end
      s5_ctx.col    <= s4_col;
      s5_ctx.row    <= s4_row;
      s5_ctx.around <= s4_around;
      s5_ctx.cx0    <= s4_cx0;
      s5_ctx.cx1    <= s4_cx1;
      s5_ctx.cy0    <= s4_cy0;
      s5_ctx.cy1    <= s4_cy1;
    end
  end

  // -------------------------------------------------------------------------
  // Divider stages: one lane per edge, context delayed alongside
  // -------------------------------------------------------------------------
  logic [L-1:0]  quo [4];
  msc_pkg::ctx_t dv_ctx [L];
  logic [L-1:0]  dv_valid;

  for (genvar e = 0; e < 4; e++) begin : g_lane
    msc_div u_div (
      .clk (clk),
      .en  (adv),
      .num (s5_num[e]),
      .den (s5_den[e]),
      .quo (quo[e])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_ctx[0] <= s5_ctx;
      for (int i = 1; i < L; i++) begin
        dv_ctx[i] <= dv_ctx[i-1];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stage 6: edge points with saturation
  // -------------------------------------------------------------------------
  logic          s6_valid;
  logic [9:0]    s6_col, s6_row;
  logic          s6_around;
  logic [3:0]    s6_pv;
  msc_pkg::pt_t  s6_pt [4];

  msc_pkg::ctx_t cx_t;
  msc_pkg::pt_t  pt_c [4];
  logic [3:0]    pv_c;

  assign cx_t = dv_ctx[L-1];

  always_comb begin
    logic [30:0]        off;
    logic signed [44:0] bx, by;
    logic signed [45:0] xs, ys;
    for (int e = 0; e < 4; e++) begin
      case (cx_t.mode[e])
        msc_pkg::MODE_START:  off = '0;
        msc_pkg::MODE_END:    off = e[0] ? step_y : step_x;
        msc_pkg::MODE_INTERP: off = quo[e];
        default:              off = '0;
      endcase
      pv_c[e] = cx_t.mode[e] != msc_pkg::MODE_NONE;
      bx = (e == 1 || e == 2) ? cx_t.cx1 : cx_t.cx0;
      by = (e >= 2) ? cx_t.cy1 : cx_t.cy0;
      xs = 46'(bx);
      ys = 46'(by);
      case (e)
        0:       xs = 46'(bx) + 46'(off);
        1:       ys = 46'(by) + 46'(off);
        2:       xs = 46'(bx) - 46'(off);
        default: ys = 46'(by) - 46'(off);
      endcase
      pt_c[e].x = msc_pkg::sat32(xs);
      pt_c[e].y = msc_pkg::sat32(ys);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_col    <= cx_t.col;
      s6_row    <= cx_t.row;
      s6_around <= cx_t.around;
      s6_pv     <= pv_c;
      s6_pt     <= pt_c;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 7: drop repeated points, pack the rest in edge order
  // -------------------------------------------------------------------------
  logic         s7_valid, s7_around;
  logic [9:0]   s7_col, s7_row;
  logic [2:0]   s7_cnt;
  msc_pkg::pt_t s7_pt [4];

  logic [2:0]   cnt_c;
  msc_pkg::pt_t cp_c [4];

  always_comb begin
    logic dup;
    cnt_c = '0;
    for (int i = 0; i < 4; i++) begin
      cp_c[i] = '0;
    end
    for (int e = 0; e < 4; e++) begin
      dup = 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < cnt_c && cp_c[i] == s6_pt[e]) begin
          dup = 1'b1;
        end
      end
      if (s6_pv[e] && !dup) begin
        cp_c[cnt_c[1:0]] = s6_pt[e];
        cnt_c = cnt_c + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_col    <= s6_col;
      s7_row    <= s6_row;
      s7_around <= s6_around;
      s7_cnt    <= cnt_c;
      s7_pt     <= cp_c;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 8: segment pairing, zero-length drop; held here while emitting
  // -------------------------------------------------------------------------
  logic         p_valid, p_idx;
  logic [1:0]   p_n;
  logic [9:0]   p_col, p_row;
  msc_pkg::seg_t p_seg [2];

  msc_pkg::seg_t c0, c1;
  logic          c0_ok, c1_ok;

  always_comb begin
    c0    = '{a: s7_pt[0], b: s7_pt[1]};
    c1    = '{a: s7_pt[2], b: s7_pt[3]};
    c0_ok = 1'b0;
    c1_ok = 1'b0;
    if (s7_cnt == 3'd2) begin
      c0_ok = c0.a != c0.b;
    end else if (s7_cnt == 3'd4) begin
      if (s7_around) begin
        c0 = '{a: s7_pt[3], b: s7_pt[0]};
        c1 = '{a: s7_pt[1], b: s7_pt[2]};
      end
      c0_ok = c0.a != c0.b;
      c1_ok = c1.a != c1.b;
    end
  end

  // Output register handshake with the held stage.
  logic load, p_done;
  assign load   = p_valid && p_n != 2'd0 && (!out_valid || out_ready);
  assign p_done = p_valid && (p_n == 2'd0 || (load && {1'b0, p_idx} == p_n - 2'd1));
  assign adv    = !p_valid || p_done;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_col    <= s7_col;
      p_row    <= s7_row;
      p_n      <= 2'(c0_ok) + 2'(c1_ok);
      p_seg[0] <= c0_ok ? c0 : c1;
      p_seg[1] <= c1;
    end
    if (load) begin
      seg_ax   <= p_seg[p_idx].a.x;
      seg_ay   <= p_seg[p_idx].a.y;
      seg_bx   <= p_seg[p_idx].b.x;
      seg_by   <= p_seg[p_idx].b.y;
      out_col  <= p_col;
      out_row  <= p_row;
      last_seg <= {1'b0, p_idx} == p_n - 2'd1;
    end
  end

  // Valid bits: advance with the pipe, clear on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      dv_valid  <= '0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      p_valid   <= 1'b0;
      p_idx     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid <= in_valid;
        s2_valid <= s1_valid;
        s3_valid <= s2_valid;
        s4_valid <= s3_valid;
        s5_valid <= s4_valid;
        dv_valid <= {dv_valid[L-2:0], s5_valid};
        s6_valid <= dv_valid[L-1];
        s7_valid <= s6_valid;
        p_valid  <= s7_valid;
        p_idx    <= 1'b0;
      end else if (load) begin
        // first of two segments sent; hold the cell for the second
        p_idx <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `MSC_ASSERT_NOW(a_empty_no_stall, p_valid && p_n == 2'd0, adv, "empty cell stalled the pipe")
  `MSC_ASSERT_NOW(a_second_idx, p_valid && p_idx, p_n == 2'd2, "second segment index without pair")
  `MSC_ASSERT_NEXT(a_pair_holds, load && !p_idx && p_n == 2'd2, p_valid && p_idx, "pair lost second segment")

endmodule
`default_nettype wire

// ----- tb/marching_squares_cell_unit_test.sv -----
// ---------------------------------------------------------------------------
// marching_squares_cell_unit_test
// Drives lattice cells into the contour cell unit and checks each segment
// against a behavioral predictor of the cell, with random idling on both
// sides and several register settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
module marching_squares_cell_unit_test;

  localparam int  MAX_COLS = msc_pkg::DEF_MAX_COLS;
  localparam int  MAX_ROWS = msc_pkg::DEF_MAX_ROWS;
  localparam int  DRAIN_CYCLES = 120;
  localparam int  RAND_ITEMS = 450;

  typedef struct {
    logic [9:0]         col;
    logic [9:0]         row;
    logic signed [31:0] ll;
    logic signed [31:0] lr;
    logic signed [31:0] ur;
    logic signed [31:0] ul;
    logic [3:0]         inv;
  } cell_item_t;

  typedef struct {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [9:0]         col;
    logic [9:0]         row;
    logic               last;
  } segment_t;

  // directed row: cell plus an optional hand-typed segment count
  typedef struct {
    cell_item_t c;
    int         nseg;  // -1: predictor only
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = msc_pkg::REG_ISO_LEVEL;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [9:0] cell_col = '0;
  logic [9:0] cell_row = '0;
  logic signed [31:0] corner_ll = '0;
  logic signed [31:0] corner_lr = '0;
  logic signed [31:0] corner_ur = '0;
  logic signed [31:0] corner_ul = '0;
  logic [3:0] corner_invalid = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] seg_ax, seg_ay, seg_bx, seg_by;
  logic [9:0] out_col, out_row;
  logic last_seg;

  // predictor copy of the register file
  logic signed [31:0] iso_q = 0;
  logic signed [31:0] xorg_q = 0;
  logic signed [31:0] yorg_q = 0;
  logic [30:0] stepx_q = 31'd65536;
  logic [30:0] stepy_q = 31'd65536;

  segment_t expected_segs[$];
  int mismatches = 0;
  bit idle_enable = 1'b0;

  always #6 clk = ~clk;

  marching_squares_cell_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cell_col(cell_col), .cell_row(cell_row),
    .corner_ll(corner_ll), .corner_lr(corner_lr),
    .corner_ur(corner_ur), .corner_ul(corner_ul),
    .corner_invalid(corner_invalid),
    .out_valid(out_valid), .out_ready(out_ready),
    .seg_ax(seg_ax), .seg_ay(seg_ay), .seg_bx(seg_bx), .seg_by(seg_by),
    .out_col(out_col), .out_row(out_row), .last_seg(last_seg)
  );

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Iso crossing on one edge; dir 0 +x, 1 +y, 2 -x, 3 -y from (sx, sy).
  function automatic bit edge_crossing(input logic signed [63:0] a, b, sx, sy,
                                       input int dir, input logic [63:0] stp,
                                       output logic signed [63:0] px, py);
    logic [63:0] ma, mb, reach;
    logic signed [63:0] off;
    px = 0;
    py = 0;
    if (a == 0 && b == 0) return 0;
    if (a == 0) reach = 0;
    else if (b == 0) reach = stp;
    else begin
      if ((a > 0) == (b > 0)) return 0;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      reach = (stp * ma) / (ma + mb);
    end
    off = $signed(reach);
    if (dir >= 2) off = -off;
    if (dir == 0 || dir == 2) begin
      px = clamp32(sx + off);
      py = clamp32(sy);
    end else begin
      px = clamp32(sx);
      py = clamp32(sy + off);
    end
    return 1;
  endfunction

  // Work out the segments of one cell and queue them.
  function automatic int predict_segments(input cell_item_t c);
    logic signed [63:0] v[4], s[4], cx[4], cy[4];
    logic signed [63:0] px[4], py[4];
    logic signed [63:0] qx, qy, sum, center;
    logic signed [63:0] iso;
    int cnt, e, n, i, p0, p1, nseg;
    bit dup, around;
    segment_t sg;
    int pair[4];
    cnt = 0;
    nseg = 0;
    if (c.col >= MAX_COLS || c.row >= MAX_ROWS) return 0;
    iso = iso_q;
    v[0] = c.ll; v[1] = c.lr; v[2] = c.ur; v[3] = c.ul;
    for (i = 0; i < 4; i++) s[i] = v[i] - iso;
    cx[0] = 64'(xorg_q) + $signed({54'd0, c.col}) * $signed({33'd0, stepx_q});
    cx[1] = cx[0] + $signed({33'd0, stepx_q});
    cx[2] = cx[1];
    cx[3] = cx[0];
    cy[0] = 64'(yorg_q) + $signed({54'd0, c.row}) * $signed({33'd0, stepy_q});
    cy[1] = cy[0];
    cy[2] = cy[0] + $signed({33'd0, stepy_q});
    cy[3] = cy[2];
    for (e = 0; e < 4; e++) begin
      n = (e + 1) % 4;
      if (c.inv[e] || c.inv[n]) continue;
      if (!edge_crossing(s[e], s[n], cx[e], cy[e], e,
                         (e % 2) ? {33'd0, stepy_q} : {33'd0, stepx_q}, qx, qy))
        continue;
      dup = 0;
      for (i = 0; i < cnt; i++) if (px[i] == qx && py[i] == qy) dup = 1;
      if (!dup) begin
        px[cnt] = qx;
        py[cnt] = qy;
        cnt++;
      end
    end
    if (cnt == 2) begin
      pair[0] = 0; pair[1] = 1; pair[2] = -1;
    end else if (cnt == 4) begin
      sum = v[0] + v[1] + v[2] + v[3];
      center = (sum >>> 2) - iso;  // arithmetic shift floors
      around = (s[0] < 0 && s[2] < 0 && center < 0) ||
               (s[0] > 0 && s[2] > 0 && center > 0);
      if (around) begin
        pair[0] = 3; pair[1] = 0; pair[2] = 1; pair[3] = 2;
      end else begin
        pair[0] = 0; pair[1] = 1; pair[2] = 2; pair[3] = 3;
      end
    end else begin
      pair[0] = -1; pair[2] = -1;
    end
    for (i = 0; i < 4; i += 2) begin
      if (pair[i] < 0) continue;
      p0 = pair[i];
      p1 = pair[i + 1];
      // drop zero-length segments
      if (px[p0] == px[p1] && py[p0] == py[p1]) continue;
      sg.ax = px[p0][31:0]; sg.ay = py[p0][31:0];
      sg.bx = px[p1][31:0]; sg.by = py[p1][31:0];
      sg.col = c.col; sg.row = c.row; sg.last = 1'b0;
      expected_segs = {expected_segs, sg};
      nseg++;
    end
    if (nseg > 0) expected_segs[expected_segs.size() - 1].last = 1'b1;
    return nseg;
  endfunction

  // Write one register through the configuration port and mirror it in the predictor.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      msc_pkg::REG_ISO_LEVEL: iso_q = val;
      msc_pkg::REG_X_ORIGIN:  xorg_q = val;
      msc_pkg::REG_Y_ORIGIN:  yorg_q = val;
      msc_pkg::REG_STEP_X:    stepx_q = val[30:0];
      msc_pkg::REG_STEP_Y:    stepy_q = val[30:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present one cell, hold it until accepted, then queue its segments.
  task automatic send_cell(input cell_item_t c, input int typed_nseg);
    int got;
    // idle before the item; valid drops only while idling
    while (idle_enable && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cell_col <= c.col; cell_row <= c.row;
    corner_ll <= c.ll; corner_lr <= c.lr;
    corner_ur <= c.ur; corner_ul <= c.ul;
    corner_invalid <= c.inv;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    got = predict_segments(c);
    if (typed_nseg >= 0 && got != typed_nseg) begin
      mismatches++;
      if (mismatches <= 10)
        $display("cell (%0d,%0d): expected %0d segments by table, predictor %0d",
                 c.col, c.row, typed_nseg, got);
    end
  endtask

  // Wait for the block to drain before touching registers.
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_segs.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return iso_q + $signed(32'($urandom_range(8))) - 4;
      3: return iso_q;
      4: return iso_q + $signed(32'($urandom_range(400000))) - 200000;
      default: return $urandom;
    endcase
  endfunction

  function automatic cell_item_t rand_cell();
    cell_item_t c;
    c.col = 10'($urandom_range(1023));
    c.row = 10'($urandom_range(1023));
    c.ll = rand_sample(); c.lr = rand_sample();
    c.ur = rand_sample(); c.ul = rand_sample();
    // mostly fully valid cells so the crossings get exercised
    c.inv = ($urandom_range(99) < 80) ? 4'd0 : 4'($urandom_range(15));
    return c;
  endfunction

  // Output side: random stall, compare every accepted segment.
  always @(posedge clk) begin
    segment_t exp_seg;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_enable && $urandom_range(99) < 26);
      if (out_valid && out_ready) begin
        if (expected_segs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected segment (%0d,%0d) -> (%0d,%0d)",
                     seg_ax, seg_ay, seg_bx, seg_by);
        end else begin
          exp_seg = expected_segs.pop_front();
          if (seg_ax !== exp_seg.ax || seg_ay !== exp_seg.ay ||
              seg_bx !== exp_seg.bx || seg_by !== exp_seg.by ||
              out_col !== exp_seg.col || out_row !== exp_seg.row ||
              last_seg !== exp_seg.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("segment mismatch: exp %0d %0d %0d %0d c%0d r%0d l%0d",
                       exp_seg.ax, exp_seg.ay, exp_seg.bx, exp_seg.by,
                       exp_seg.col, exp_seg.row, exp_seg.last);
              $display("                  got %0d %0d %0d %0d c%0d r%0d l%0d",
                       seg_ax, seg_ay, seg_bx, seg_by, out_col, out_row, last_seg);
            end
          end
        end
      end
    end
  end

  // Hard stop on a hung run.
  initial begin
    #(12 * 400000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    row_t directed[$];
    row_t r;
    cell_item_t c;
    int i, phase;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table; counts typed only where they are obvious
    r.c = '{10'd0, 10'd0, 0, 0, 0, 0, 4'd0}; r.nseg = 0;           directed = {directed, r};
    r.c = '{10'd0, 10'd0, -65536, 65536, 65536, -65536, 4'd0}; r.nseg = 1; directed = {directed, r};
    r.c = '{10'd5, 10'd7, 100, 200, 300, 400, 4'd0}; r.nseg = 0;   directed = {directed, r};
    r.c = '{10'd5, 10'd7, -100, -200, -300, -400, 4'd0}; r.nseg = 0; directed = {directed, r};
    r.c = '{10'd1, 10'd1, -65536, 65536, 65536, -65536, 4'hF}; r.nseg = 0; directed = {directed, r};
    r.c = '{10'd1, 10'd1, -65536, 65536, 65536, -65536, 4'h1}; r.nseg = -1; directed = {directed, r};
    r.c = '{10'd1023, 10'd1023, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh8000_0000, 4'd0}; r.nseg = 2;     directed = {directed, r};
    r.c = '{10'd2, 10'd3, -10, 10, -10, 10, 4'd0}; r.nseg = 2;     directed = {directed, r};
    r.c = '{10'd2, 10'd3, 10, -10, 10, -10, 4'd0}; r.nseg = 2;     directed = {directed, r};
    r.c = '{10'd2, 10'd3, -10, 10, -10, 11, 4'd0}; r.nseg = -1;    directed = {directed, r};
    r.c = '{10'd4, 10'd4, 0, 100, 0, -100, 4'd0}; r.nseg = -1;     directed = {directed, r};
    r.c = '{10'd4, 10'd4, 0, 0, 100, 100, 4'd0}; r.nseg = -1;      directed = {directed, r};
    r.c = '{10'd4, 10'd4, 0, 100, 100, 100, 4'd0}; r.nseg = 0;     directed = {directed, r};
    r.c = '{10'd9, 10'd9, 1, -3, 7, -1, 4'h2}; r.nseg = -1;        directed = {directed, r};
    r.c = '{10'd9, 10'd9, 1, -3, 7, -1, 4'h8}; r.nseg = -1;        directed = {directed, r};
    r.c = '{10'd9, 10'd9, 1, -3, 7, -1, 4'h4}; r.nseg = -1;        directed = {directed, r};
    foreach (directed[k]) send_cell(directed[k].c, directed[k].nseg);
    wait_idle();

    // extreme origin and step: coordinates saturate, then a zero step
    write_reg(msc_pkg::REG_X_ORIGIN, 32'h7FFF_0000);
    write_reg(msc_pkg::REG_Y_ORIGIN, 32'h8000_0000);
    write_reg(msc_pkg::REG_STEP_X, 32'h7FFF_FFFF);
    write_reg(msc_pkg::REG_STEP_Y, 32'h0000_0001);
    write_reg(msc_pkg::REG_ISO_LEVEL, 32'h8000_0000);
    r.c = '{10'd1023, 10'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 5, 32'sh8000_0000, 4'd0};
    send_cell(r.c, -1);
    wait_idle();
    write_reg(msc_pkg::REG_ISO_LEVEL, 32'h7FFF_FFFF);
    send_cell('{10'd3, 10'd1023, 32'sh7FFF_FFFF, 0, -5, 32'sh7FFF_FFFF, 4'd0}, -1);
    wait_idle();
    write_reg(msc_pkg::REG_STEP_X, 32'h0);
    send_cell('{10'd8, 10'd8, -5, 5, 5, -5, 4'd0}, -1);
    wait_idle();

    // random phases across register settings; first phase runs without idling
    for (phase = 0; phase < 5; phase++) begin
      write_reg(msc_pkg::REG_ISO_LEVEL, (phase == 0) ? 32'd0 : $urandom);
      write_reg(msc_pkg::REG_X_ORIGIN,
                (phase == 1) ? 32'h8000_0000 : $urandom_range(200000));
      write_reg(msc_pkg::REG_Y_ORIGIN, (phase == 2) ? 32'h7FFF_FFFF : $urandom);
      write_reg(msc_pkg::REG_STEP_X,
                (phase == 3) ? 32'h7FFF_FFFF : 32'($urandom_range(1, 1 << 18)));
      write_reg(msc_pkg::REG_STEP_Y,
                (phase == 4) ? 32'd1 : 32'($urandom_range(1, 1 << 18)));
      idle_enable = (phase != 0);
      for (i = 0; i < RAND_ITEMS / 5; i++) begin
        c = rand_cell();
        send_cell(c, -1);
      end
      wait_idle();
    end

    if (mismatches == 0 && expected_segs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- marching_squares_cell_unit.f -----
+incdir+src
src/msc_pkg.sv
src/msc_div.sv
src/marching_squares_cell_unit.sv
tb/marching_squares_cell_unit_test.sv
